>>> rtl/core/binary_image_thinning_defines.svh
// Assertion helpers shared by the core files.
`ifndef BINARY_IMAGE_THINNING_DEFINES_SVH
`define BINARY_IMAGE_THINNING_DEFINES_SVH

// Property that must hold at every edge outside reset.
`define BITHIN_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("bithin check failed");

// Antecedent in one cycle implies consequent in the next.
`define BITHIN_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bithin sequence check failed");

`endif

>>> rtl/core/bithin_pkg.sv
package bithin_pkg;

   localparam int DEF_MAX_COLS = 128;
   localparam int DEF_MAX_ROWS = 128;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_RUN   = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic REG_COLS = 1'b0;
   localparam logic REG_ROWS = 1'b1;

   localparam logic [7:0] SIZE_RESET = 8'd128;
   localparam logic [7:0] PIX_FG     = 8'd255;
   localparam logic [7:0] ITER_MAX   = 8'd255;
   localparam logic [3:0] NBR_LAST   = 4'd8;

   typedef struct packed {
      logic [1:0] operation;
      logic [6:0] row_index;
      logic [6:0] col_index;
      logic [7:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] pixel_out;
      logic [7:0] iteration_count;
   } rsp_type;

   typedef struct packed {
      logic user_wr;
      logic user_rd;
      logic rsp_read;
      logic rsp_run;
      logic scan_start;
      logic scan_next;
      logic fetch;
      logic eval_wr;
      logic mark_rd;
      logic clear_wr;
      logic odd;
      logic iter_clear;
      logic iter_inc;
      logic flag_clear;
   } cmd_type;

   typedef struct packed {
      logic small_image;
      logic scan_last;
      logic fetch_last;
      logic removed;
   } sts_type;

   // Fetch order: centre, then p2..p9 clockwise from north.
   function automatic logic signed [1:0] nbr_dr(input logic [3:0] k);
      case (k)
         4'd1, 4'd2, 4'd8: nbr_dr = -2'sd1;
         4'd4, 4'd5, 4'd6: nbr_dr = 2'sd1;
         default:          nbr_dr = 2'sd0;
      endcase
   endfunction

   function automatic logic signed [1:0] nbr_dc(input logic [3:0] k);
      case (k)
         4'd2, 4'd3, 4'd4: nbr_dc = 2'sd1;
         4'd6, 4'd7, 4'd8: nbr_dc = -2'sd1;
         default:          nbr_dc = 2'sd0;
      endcase
   endfunction

endpackage

>>> rtl/core/binary_image_thinning.sv
// Zhang-Suen thinning engine over an on-chip binary frame store.
// Input channel: an item is taken on a clock edge with start high and busy
//   low. Operations: write pixel, run thinning, read pixel.
// A write gives no result; busy stays low.
// A read gives a result strobe (rsp_valid), registered after the S_RD_WAIT state.
// A run holds busy high; each iteration is two sub-passes, each a mark
//   sweep (per interior pixel: nine single-port store reads, a wait
//   state for the read data, one mark write) and a clear sweep (a mark
//   read and a clear write per pixel). The single read port of the frame
//   store sets the length of the mark sweep.
// rsp_valid is high for exactly one cycle per result; rsp_data holds it; the receiver cannot stall.
// Config: csr_we/csr_index/csr_wdata, written only while idle; the user is bound to this, the block has no check.
// Reset: sizes return to 128x128, the iteration count and removal flag
//   clear; the frame store keeps no reset and must be written before use.
module binary_image_thinning #(
   parameter int MAX_COLS = bithin_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = bithin_pkg::DEF_MAX_ROWS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  bithin_pkg::req_type req,
   output logic                rsp_valid,
   output bithin_pkg::rsp_type rsp_data,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [7:0]          csr_wdata
);
   import bithin_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: sweeps, sub-pass parity and iteration loop
   bithin_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req.operation),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy)
   );

   // frame store, marks, scan counters and neighbourhood tests
   bithin_dp #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> rtl/core/bithin_dp.sv
`include "binary_image_thinning_defines.svh"

module bithin_dp #(
   parameter int MAX_COLS = bithin_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = bithin_pkg::DEF_MAX_ROWS
) (
   input  logic               clock,
   input  logic               reset,
   input  bithin_pkg::req_type req,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [7:0]         csr_wdata,
   input  bithin_pkg::cmd_type cmd,
   output bithin_pkg::sts_type sts,
   output logic               rsp_valid,
   output bithin_pkg::rsp_type rsp_data
);
   import bithin_pkg::*;

   localparam int SRW   = $clog2(MAX_ROWS + 1);
   localparam int SCW   = $clog2(MAX_COLS + 1);
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(DEPTH);

   logic [7:0]     cols_ff, rows_ff;
   logic [SCW-1:0] eff_cols;
   logic [SRW-1:0] eff_rows;
   logic [RW-1:0]  r_ff, r_in, rr;
   logic [CW-1:0]  c_ff, c_in, cc;
   logic [3:0]     k_ff, k_in;
   logic           fetch_d_ff;
   logic [8:0]     win_ff;
   logic [7:0]     iter_ff, iter_in;
   logic           removed_ff, removed_in;
   logic           in_area, in_area_d_ff;
   logic           last_c, last_r;
   logic [AW-1:0]  user_addr, fetch_addr, centre_addr;
   logic           img_mem [DEPTH];
   logic           mark_mem [DEPTH];
   logic           img_q, mark_q;
   logic           img_we, img_wdata;
   logic [AW-1:0]  img_waddr, img_raddr;
   logic [3:0]     trans, nb;
   logic [7:0]     n;
   logic           m1, m2, mark;
   logic           rsp_valid_ff;
   rsp_type        rsp_ff, rsp_in;

   // effective sizes, saturated into 1..MAX
   assign eff_cols = (cols_ff == 8'd0) ? SCW'(1) :
                     ((12'(cols_ff) > 12'(MAX_COLS)) ? SCW'(MAX_COLS) : SCW'(cols_ff));
   assign eff_rows = (rows_ff == 8'd0) ? SRW'(1) :
                     ((12'(rows_ff) > 12'(MAX_ROWS)) ? SRW'(MAX_ROWS) : SRW'(rows_ff));

   assign in_area = (12'(req.row_index) < 12'(eff_rows)) &&
                    (12'(req.col_index) < 12'(eff_cols));

   assign last_c = (12'(c_ff) == 12'(eff_cols) - 12'd2);
   assign last_r = (12'(r_ff) == 12'(eff_rows) - 12'd2);

   assign sts.small_image = (12'(eff_rows) < 12'd3) || (12'(eff_cols) < 12'd3);
   assign sts.scan_last   = last_c && last_r;
   assign sts.fetch_last  = (k_ff == NBR_LAST);
   assign sts.removed     = removed_ff;

   assign rr = r_ff + RW'(nbr_dr(k_ff));
   assign cc = c_ff + CW'(nbr_dc(k_ff));

   assign user_addr   = AW'(req.row_index) * AW'(MAX_COLS) + AW'(req.col_index);
   assign fetch_addr  = AW'(rr) * AW'(MAX_COLS) + AW'(cc);
   assign centre_addr = AW'(r_ff) * AW'(MAX_COLS) + AW'(c_ff);

   assign img_we    = (cmd.user_wr && in_area) || (cmd.clear_wr && mark_q);
   assign img_wdata = cmd.user_wr ? (req.pixel_in == PIX_FG) : 1'b0;
   assign img_waddr = cmd.user_wr ? user_addr : centre_addr;
   assign img_raddr = cmd.user_rd ? user_addr : fetch_addr;

   // thinning tests over window p2..p9
   always_comb begin
      n     = win_ff[8:1];
      trans = 4'd0;
      for (int i = 0; i < 8; i++) begin
         trans = trans + 4'(!n[i] && n[(i + 1) % 8]);
      end
      nb = 4'($countones(n));
      if (cmd.odd) begin
         m1 = n[0] & n[2] & n[6];
         m2 = n[0] & n[4] & n[6];
      end else begin
         m1 = n[0] & n[2] & n[4];
         m2 = n[2] & n[4] & n[6];
      end
      mark = win_ff[0] && (trans == 4'd1) && (nb >= 4'd2) && (nb <= 4'd6) && !m1 && !m2;
   end

   always_comb begin
      r_in = r_ff;
      c_in = c_ff;
      if (cmd.scan_start) begin
         r_in = RW'(1);
         c_in = CW'(1);
      end else if (cmd.scan_next) begin
         if (last_c) begin
            c_in = CW'(1);
            r_in = r_ff + RW'(1);
         end else begin
            c_in = c_ff + CW'(1);
         end
      end
      k_in = cmd.fetch ? k_ff + 4'd1 : 4'd0;

      iter_in = iter_ff;
      if (cmd.iter_clear) begin
         iter_in = 8'd0;
      end else if (cmd.iter_inc && iter_ff != ITER_MAX) begin
         iter_in = iter_ff + 8'd1;
      end

      removed_in = removed_ff;
      if (cmd.flag_clear) begin
         removed_in = 1'b0;
      end else if (cmd.clear_wr && mark_q) begin
         removed_in = 1'b1;
      end

      rsp_in = rsp_ff;
      if (cmd.rsp_run) begin
         rsp_in = '{result_kind: 1'b1, pixel_out: 8'd0, iteration_count: iter_ff};
      end else if (cmd.rsp_read) begin
         rsp_in = '{result_kind: 1'b0,
                    pixel_out: (in_area_d_ff && img_q) ? PIX_FG : 8'd0,
                    iteration_count: 8'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= SIZE_RESET;
         rows_ff      <= SIZE_RESET;
         k_ff         <= 4'd0;
         fetch_d_ff   <= 1'b0;
         iter_ff      <= 8'd0;
         removed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_COLS: cols_ff <= csr_wdata;
               REG_ROWS: rows_ff <= csr_wdata;
               default:  ;
            endcase
         end
         k_ff         <= k_in;
         fetch_d_ff   <= cmd.fetch;
         iter_ff      <= iter_in;
         removed_ff   <= removed_in;
         rsp_valid_ff <= cmd.rsp_run || cmd.rsp_read;
      end
   end

   always_ff @(posedge clock) begin
      r_ff         <= r_in;
      c_ff         <= c_in;
      in_area_d_ff <= in_area;
      rsp_ff       <= rsp_in;
      if (fetch_d_ff) begin
         win_ff <= {img_q, win_ff[8:1]};
      end
   end

   // frame store
   always_ff @(posedge clock) begin
      if (img_we) begin
         img_mem[img_waddr] <= img_wdata;
      end
      img_q <= img_mem[img_raddr];
   end

   // removal marks of the current sub-pass
   always_ff @(posedge clock) begin
      if (cmd.eval_wr) begin
         mark_mem[centre_addr] <= mark;
      end
      if (cmd.mark_rd) begin
         mark_q <= mark_mem[centre_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `BITHIN_ASSERT_NEXT(a_rsp_single, rsp_valid_ff, !rsp_valid_ff)
   `BITHIN_ASSERT(a_read_no_count,
      !(rsp_valid_ff && !rsp_ff.result_kind) || (rsp_ff.iteration_count == 8'd0))
   `BITHIN_ASSERT_NEXT(a_removed_sets, cmd.clear_wr && mark_q && !cmd.flag_clear, removed_ff)

endmodule

>>> rtl/core/bithin_ctrl.sv
`include "binary_image_thinning_defines.svh"

module bithin_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          operation,
   input  bithin_pkg::sts_type sts,
   output bithin_pkg::cmd_type cmd,
   output logic                busy
);
   import bithin_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_RD_WAIT, S_ITER, S_FETCH, S_FETCH_WAIT, S_EVAL,
      S_CLR_RD, S_CLR_WR, S_ITER_END, S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      odd_ff, odd_in;

   always_comb begin
      state_in = state_ff;
      odd_in   = odd_ff;
      cmd      = '0;
      cmd.odd  = odd_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (operation)
                  OP_WRITE: cmd.user_wr = 1'b1;
                  OP_RUN: begin
                     cmd.iter_clear = 1'b1;
                     state_in       = S_ITER;
                  end
                  OP_READ: begin
                     cmd.user_rd = 1'b1;
                     state_in    = S_RD_WAIT;
                  end
                  default: ;
               endcase
            end
         end
         S_RD_WAIT: begin
            cmd.rsp_read = 1'b1;
            state_in     = S_IDLE;
         end
         S_ITER: begin
            cmd.flag_clear = 1'b1;
            if (sts.small_image) begin
               state_in = S_ITER_END;
            end else begin
               cmd.scan_start = 1'b1;
               odd_in         = 1'b0;
               state_in       = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            if (sts.fetch_last) begin
               state_in = S_FETCH_WAIT;
            end
         end
         S_FETCH_WAIT: state_in = S_EVAL;
         S_EVAL: begin
            cmd.eval_wr = 1'b1;
            if (sts.scan_last) begin
               cmd.scan_start = 1'b1;
               state_in       = S_CLR_RD;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_FETCH;
            end
         end
         S_CLR_RD: begin
            cmd.mark_rd = 1'b1;
            state_in    = S_CLR_WR;
         end
         S_CLR_WR: begin
            cmd.clear_wr = 1'b1;
            if (sts.scan_last) begin
               if (!odd_ff) begin
                  odd_in         = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in       = S_FETCH;
               end else begin
                  state_in = S_ITER_END;
               end
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_CLR_RD;
            end
         end
         S_ITER_END: begin
            cmd.iter_inc = 1'b1;
            state_in     = sts.removed ? S_ITER : S_DONE;
         end
         S_DONE: begin
            cmd.rsp_run = 1'b1;
            state_in    = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         odd_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         odd_ff   <= odd_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   `BITHIN_ASSERT_NEXT(a_run_goes_busy, start && !busy && operation == OP_RUN, busy)
   `BITHIN_ASSERT(a_fetch_eval_apart, !(cmd.fetch && cmd.eval_wr))
   `BITHIN_ASSERT(a_user_only_idle, !(cmd.user_wr || cmd.user_rd) || !busy)

endmodule

>>> bench/binary_image_thinning_checker.sv
`timescale 1ns / 1ps

module binary_image_thinning_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                busy,
   input  bithin_pkg::req_type req,
   input  logic                rsp_valid,
   input  bithin_pkg::rsp_type rsp_data,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [7:0]          csr_wdata,
   output int                  failures,
   output int                  pending
);
   import bithin_pkg::*;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_RUN  = 1'b1;

   bit        frame [0:127][0:127];
   bit        marks [0:127][0:127];
   bit [7:0]  cols_reg;
   bit [7:0]  rows_reg;
   rsp_type   expected_rsp [$];
   int        err_count;

   initial begin
      failures = 0;
      pending = 0;
      err_count = 0;
      cols_reg = SIZE_RESET;
      rows_reg = SIZE_RESET;
   end

   function automatic int clamp_size(input bit [7:0] v);
      if (v == 0) return 1;
      if (v > 128) return 128;
      return int'(v);
   endfunction

   // one parallel sub-pass: mark everything first, then clear
   function automatic bit thin_sweep(input int rows, input int cols, input bit odd);
      bit removed;
      bit nb [0:8];
      int a, b;
      bit m1, m2;
      removed = 0;
      if (rows < 3 || cols < 3) return 0;
      for (int r = 1; r + 1 < rows; r++) begin
         for (int c = 1; c + 1 < cols; c++) begin
            nb[0] = frame[r-1][c];
            nb[1] = frame[r-1][c+1];
            nb[2] = frame[r][c+1];
            nb[3] = frame[r+1][c+1];
            nb[4] = frame[r+1][c];
            nb[5] = frame[r+1][c-1];
            nb[6] = frame[r][c-1];
            nb[7] = frame[r-1][c-1];
            nb[8] = nb[0];
            a = 0;
            b = 0;
            for (int k = 0; k < 8; k++) begin
               if (!nb[k] && nb[k+1]) a++;
               b += nb[k];
            end
            if (odd) begin
               m1 = nb[0] & nb[2] & nb[6];
               m2 = nb[0] & nb[4] & nb[6];
            end else begin
               m1 = nb[0] & nb[2] & nb[4];
               m2 = nb[2] & nb[4] & nb[6];
            end
            marks[r][c] = frame[r][c] && a == 1 && b >= 2 && b <= 6 && !m1 && !m2;
         end
      end
      for (int r = 1; r + 1 < rows; r++)
         for (int c = 1; c + 1 < cols; c++)
            if (marks[r][c]) begin
               frame[r][c] = 0;
               removed = 1;
            end
      return removed;
   endfunction

   function automatic bit [7:0] thin_frame(input int rows, input int cols);
      bit [7:0] iters;
      bit       even_rm, odd_rm;
      iters = 0;
      do begin
         even_rm = thin_sweep(rows, cols, 1'b0);
         odd_rm = thin_sweep(rows, cols, 1'b1);
         if (iters < ITER_MAX) iters++;
      end while (even_rm || odd_rm);
      return iters;
   endfunction

   always @(posedge clock) begin
      int      rows, cols;
      bit      in_area;
      rsp_type want;
      if (reset) begin
         expected_rsp.delete();
         cols_reg = SIZE_RESET;
         rows_reg = SIZE_RESET;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_COLS) cols_reg = csr_wdata;
            else rows_reg = csr_wdata;
         end
         if (start && !busy) begin
            rows = clamp_size(rows_reg);
            cols = clamp_size(cols_reg);
            in_area = req.row_index < rows && req.col_index < cols;
            case (req.operation)
               OP_WRITE: if (in_area) frame[req.row_index][req.col_index] = req.pixel_in == PIX_FG;
               OP_RUN: begin
                  want.result_kind = KIND_RUN;
                  want.pixel_out = 8'd0;
                  want.iteration_count = thin_frame(rows, cols);
                  expected_rsp = {expected_rsp, want};
               end
               OP_READ: begin
                  want.result_kind = KIND_READ;
                  want.pixel_out = (in_area && frame[req.row_index][req.col_index]) ? PIX_FG : 8'd0;
                  want.iteration_count = 8'd0;
                  expected_rsp = {expected_rsp, want};
               end
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected result kind=%0d pixel=%0d iter=%0d", rsp_data.result_kind,
                      rsp_data.pixel_out, rsp_data.iteration_count);
               err_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.result_kind !== want.result_kind) begin
                  $error("result_kind expected %0d actual %0d", want.result_kind,
                         rsp_data.result_kind);
                  err_count++;
               end
               if (rsp_data.pixel_out !== want.pixel_out) begin
                  $error("pixel_out expected %0d actual %0d", want.pixel_out, rsp_data.pixel_out);
                  err_count++;
               end
               if (rsp_data.iteration_count !== want.iteration_count) begin
                  $error("iteration_count expected %0d actual %0d", want.iteration_count,
                         rsp_data.iteration_count);
                  err_count++;
               end
            end
         end
      end
      failures <= err_count;
      pending <= expected_rsp.size();
   end
endmodule

>>> bench/binary_image_thinning_tb.sv
`timescale 1ns / 1ps

module binary_image_thinning_tb;
   import bithin_pkg::*;

   localparam logic [1:0] OP_NONE = 2'd3;
   // a run can take up to ~127 iterations on a 3x128 frame
   localparam int IDLE_LIMIT = 2000000;
   localparam int ITEM_GOAL  = 530;

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_we = 0;
   logic    csr_index = REG_COLS;
   logic [7:0] csr_wdata = '0;
   int      failures, pending;

   // written-pixel map: reads and runs only touch pixels that hold data
   bit      written [0:127][0:127];
   int      cur_rows = 128, cur_cols = 128;
   bit      no_gaps;
   int      item_count, n_write, n_read, n_run, n_noop, n_sizes;
   int      idle_cycles;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   binary_image_thinning dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   binary_image_thinning_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .pending(pending)
   );

   // watchdog: cycles in which no item and no result moves
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL binary_image_thinning");
         $finish;
      end
   end

   function automatic int clamp_size(input bit [7:0] v);
      if (v == 0) return 1;
      if (v > 128) return 128;
      return int'(v);
   endfunction

   function automatic bit frame_full();
      for (int r = 0; r < cur_rows; r++)
         for (int c = 0; c < cur_cols; c++)
            if (!written[r][c]) return 0;
      return 1;
   endfunction

   // one item, then the sender's random gap
   task automatic send_item(input logic [1:0] op, input int row, input int col,
                            input int pix);
      int gap;
      req <= '{operation: op, row_index: row[6:0], col_index: col[6:0],
               pixel_in: pix[7:0]};
      start <= 1;
      do @(posedge clock); while (busy);
      case (op)
         OP_WRITE: begin
            n_write++;
            if (row < cur_rows && col < cur_cols) written[row][col] = 1;
         end
         OP_RUN:  n_run++;
         OP_READ: n_read++;
         default: n_noop++;
      endcase
      item_count++;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold the sender off until every result is in, plus the write latency
   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_size(input bit [7:0] cols_v, input bit [7:0] rows_v);
      drain();
      csr_we <= 1;
      csr_index <= REG_COLS;
      csr_wdata <= cols_v;
      @(posedge clock);
      csr_index <= REG_ROWS;
      csr_wdata <= rows_v;
      @(posedge clock);
      csr_we <= 0;
      cur_cols = clamp_size(cols_v);
      cur_rows = clamp_size(rows_v);
      n_sizes++;
   endtask

   // random grey value, foreground at fg_pct percent so shapes survive a pass or two
   function automatic int grey(input int fg_pct);
      if ($urandom_range(0, 99) < fg_pct) return int'(PIX_FG);
      return $urandom_range(0, 254);
   endfunction

   task automatic fill_frame();
      int fg_pct;
      fg_pct = $urandom_range(40, 85);
      for (int r = 0; r < cur_rows; r++)
         for (int c = 0; c < cur_cols; c++)
            send_item(OP_WRITE, r, c, grey(fg_pct));
   endtask

   task automatic random_op();
      int sel, row, col;
      sel = $urandom_range(0, 99);
      // mostly inside the active area, now and then anywhere
      if ($urandom_range(0, 4) == 0) begin
         row = $urandom_range(0, 127);
         col = $urandom_range(0, 127);
      end else begin
         row = $urandom_range(0, cur_rows - 1);
         col = $urandom_range(0, cur_cols - 1);
      end
      if (sel < 3) drain();  // sender pause until everything is back
      if (sel < 45) send_item(OP_WRITE, row, col, grey(60));
      else if (sel < 82) begin
         if (row < cur_rows && col < cur_cols && !written[row][col])
            send_item(OP_WRITE, row, col, grey(60));
         else
            send_item(OP_READ, row, col, $urandom_range(0, 255));
      end else if (sel < 92) begin
         if (frame_full()) send_item(OP_RUN, row, col, $urandom_range(0, 255));
         else send_item(OP_NONE, row, col, $urandom_range(0, 255));
      end else send_item(OP_NONE, row, col, $urandom_range(0, 255));
   endtask

   initial begin
      int pick;
      bit [7:0] cv, rv;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: 4x4 frame, plus and minus edge values, every operation
      no_gaps = 0;
      set_size(8'd4, 8'd4);
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            send_item(OP_WRITE, r, c, (r == 0 && c == 0) ? 254 :
                      (r == 3 && c == 3) ? 0 : PIX_FG);
      send_item(OP_READ, 0, 0, 0);
      send_item(OP_READ, 1, 1, 0);
      send_item(OP_RUN, 127, 127, 255);
      send_item(OP_READ, 2, 2, 0);
      send_item(OP_NONE, 127, 127, 255);
      send_item(OP_WRITE, 127, 127, PIX_FG);   // outside, dropped
      send_item(OP_READ, 127, 127, 255);
      send_item(OP_READ, 0, 127, 0);
      // register value 0 acts as one: no interior, run ends at once
      set_size(8'd0, 8'd0);
      send_item(OP_READ, 0, 0, 0);
      send_item(OP_RUN, 0, 0, 0);

      // random phases, each at its own frame size
      while (item_count < ITEM_GOAL) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: begin cv = 8'($urandom_range(129, 255)); rv = 8'd3; end
            1: begin cv = 8'd3; rv = 8'd128; end
            2: begin cv = 8'($urandom_range(0, 2)); rv = 8'($urandom_range(1, 6)); end
            3: begin cv = 8'd128; rv = 8'd255; end
            default: begin cv = 8'($urandom_range(3, 8)); rv = 8'($urandom_range(3, 8)); end
         endcase
         set_size(cv, rv);
         no_gaps = $urandom_range(0, 3) == 0;
         // fill only when it keeps the item total near the goal
         if (cur_rows * cur_cols <= 400 && item_count + cur_rows * cur_cols < ITEM_GOAL)
            fill_frame();
         repeat ($urandom_range(15, 30)) random_op();
         if (frame_full()) send_item(OP_RUN, 0, 0, 0);
      end

      drain();
      repeat (40) @(posedge clock);
      $display("covered %0d writes, %0d reads, %0d runs, %0d ignored items", n_write, n_read,
               n_run, n_noop);
      $display("over %0d frame size settings", n_sizes);
      if (failures == 0 && pending == 0) $display("PASS binary_image_thinning");
      else $display("FAIL binary_image_thinning");
      $finish;
   end
endmodule

>>> binary_image_thinning.f
+incdir+rtl/core
rtl/core/bithin_pkg.sv
rtl/core/bithin_dp.sv
rtl/core/bithin_ctrl.sv
rtl/core/binary_image_thinning.sv
bench/binary_image_thinning_checker.sv
bench/binary_image_thinning_tb.sv
